// ===== design/hlpf_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hlpf_pkg
// Shared constants, token types and the Q1.14 sine table of the Hough line
// peak finder.
// ---------------------------------------------------------------------------
package hlpf_pkg;

   localparam int ANGLES     = 180;
   localparam int RHO_MAX    = 725;
   localparam int RHO_ROWS   = 2 * RHO_MAX + 1;
   localparam int ADDR_WIDTH = $clog2(RHO_ROWS);
   localparam int VOTE_WIDTH = 16;
   localparam int COORD_WIDTH = 9;
   localparam logic [VOTE_WIDTH-1:0] VOTE_SAT = '1;

   localparam logic [1:0] REG_THRESHOLD  = 2'd0;
   localparam logic [1:0] REG_ANGLE_STEP = 2'd1;
   localparam logic [1:0] REG_RHO_LIMIT  = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GAP,
      ST_DRAIN,
      ST_SWEEP,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                   valid;
      logic [COORD_WIDTH-1:0] row;
      logic [COORD_WIDTH-1:0] col;
      logic [7:0]             phase;
   } vote_tok_type;

   typedef struct packed {
      logic                  valid;
      logic                  last;
      logic                  in_range;
      logic [ADDR_WIDTH-1:0] addr;
      logic [VOTE_WIDTH-1:0] votes;
      logic [7:0]            theta;
   } scan_tok_type;

   localparam logic signed [15:0] SIN_QUARTER [0:90] = '{
      16'sd0,     16'sd286,   16'sd572,   16'sd857,   16'sd1143,
      16'sd1428,  16'sd1713,  16'sd1997,  16'sd2280,  16'sd2563,
      16'sd2845,  16'sd3126,  16'sd3406,  16'sd3686,  16'sd3964,
      16'sd4240,  16'sd4516,  16'sd4790,  16'sd5063,  16'sd5334,
      16'sd5604,  16'sd5872,  16'sd6138,  16'sd6402,  16'sd6664,
      16'sd6924,  16'sd7182,  16'sd7438,  16'sd7692,  16'sd7943,
      16'sd8192,  16'sd8438,  16'sd8682,  16'sd8923,  16'sd9162,
      16'sd9397,  16'sd9630,  16'sd9860,  16'sd10087, 16'sd10311,
      16'sd10531, 16'sd10749, 16'sd10963, 16'sd11174, 16'sd11381,
      16'sd11585, 16'sd11786, 16'sd11982, 16'sd12176, 16'sd12365,
      16'sd12551, 16'sd12733, 16'sd12911, 16'sd13085, 16'sd13255,
      16'sd13421, 16'sd13583, 16'sd13741, 16'sd13894, 16'sd14044,
      16'sd14189, 16'sd14330, 16'sd14466, 16'sd14598, 16'sd14726,
      16'sd14849, 16'sd14968, 16'sd15082, 16'sd15191, 16'sd15296,
      16'sd15396, 16'sd15491, 16'sd15582, 16'sd15668, 16'sd15749,
      16'sd15826, 16'sd15897, 16'sd15964, 16'sd16026, 16'sd16083,
      16'sd16135, 16'sd16182, 16'sd16225, 16'sd16262, 16'sd16294,
      16'sd16322, 16'sd16344, 16'sd16362, 16'sd16374, 16'sd16382,
      16'sd16384
   };

   function automatic logic signed [15:0] sin_q14(input int d);
      if (d <= 90) begin
         return SIN_QUARTER[d];
      end
      return SIN_QUARTER[180 - d];
   endfunction

   function automatic logic signed [15:0] cos_q14(input int d);
      if (d <= 90) begin
         return SIN_QUARTER[90 - d];
      end
      return -SIN_QUARTER[d - 90];
   endfunction

endpackage

// ===== design/hlpf_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hlpf_cell
// One angle of the accumulator: votes pixels into its own rho column and
// takes part in the row by row peak scan, clearing each row as it is read.
// ---------------------------------------------------------------------------
module hlpf_cell
   import hlpf_pkg::*;
#(
   parameter int ANGLE = 0
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   step,
   input  vote_tok_type vote_in,
   output vote_tok_type vote_out,
   input  scan_tok_type scan_in,
   output scan_tok_type scan_out
);

   localparam logic signed [15:0] COS_Q = cos_q14(ANGLE);
   localparam logic signed [15:0] SIN_Q = sin_q14(ANGLE);

   vote_tok_type vote_ff;
   scan_tok_type scan_ff;
   scan_tok_type sd_ff;
   logic v1_ff;
   logic v2_ff;
   logic signed [25:0] pc_ff;
   logic signed [25:0] ps_ff;
   logic [ADDR_WIDTH-1:0] a2_ff;
   logic [VOTE_WIDTH-1:0] rd_ff;
   logic [VOTE_WIDTH-1:0] mem [0:RHO_ROWS-1];

   logic [7:0] step_m1;
   logic signed [26:0] sum;
   logic [26:0] mag;
   logic signed [12:0] rho;
   logic rho_ok;
   logic [ADDR_WIDTH-1:0] vaddr;
   logic [ADDR_WIDTH-1:0] rd_addr;
   logic [VOTE_WIDTH-1:0] inc;

   always_comb begin
      step_m1 = (step == 8'd0) ? 8'd0 : step - 8'd1;
      vote_out = vote_ff;
      vote_out.phase = (vote_ff.phase == 8'd0) ? step_m1 : vote_ff.phase - 8'd1;
   end

   always_comb begin
      sum = 27'(pc_ff) + 27'(ps_ff);
      mag = sum[26] ? 27'(-sum) : 27'(sum);
      rho = sum[26] ? -$signed(mag[26:14]) : $signed(mag[26:14]);
      rho_ok = (rho >= -13'sd725) && (rho <= 13'sd725);
      vaddr = ADDR_WIDTH'(rho + 13'(RHO_MAX));
      rd_addr = v1_ff ? vaddr : scan_ff.addr;
      inc = (rd_ff == VOTE_SAT) ? rd_ff : rd_ff + 1'b1;
   end

   always_comb begin
      scan_out = sd_ff;
      if (sd_ff.in_range && (rd_ff > sd_ff.votes)) begin
         scan_out.votes = rd_ff;
         scan_out.theta = 8'(ANGLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vote_ff <= '0;
         scan_ff <= '0;
         sd_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         vote_ff <= vote_in;
         scan_ff <= scan_in;
         sd_ff <= scan_ff;
         v1_ff <= vote_ff.valid && (vote_ff.phase == 8'd0);
         v2_ff <= v1_ff && rho_ok;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff <= $signed({1'b0, vote_ff.col}) * COS_Q;
      ps_ff <= $signed({1'b0, vote_ff.row}) * SIN_Q;
      a2_ff <= vaddr;
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
      if (v2_ff) begin
         mem[a2_ff] <= inc;
      end else if (scan_ff.valid) begin
         mem[scan_ff.addr] <= '0;
      end
   end

endmodule

// ===== design/hough_line_peak_finder.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hough_line_peak_finder
// Hough line accumulator built as a chain of 180 angle cells with a peak
// scan that runs through the same chain at the end of each frame.
// ---------------------------------------------------------------------------
//  channel   ports                                    direction
//  request   start, busy, req_pixel/row/col/last_pixel  in, busy out
//  result    rsp_strobe, rsp_found/peak_*            out
//  config    csr_we, csr_index, csr_wdata            in
//
// A pixel request is taken only while idle; busy then covers a gap state.
// Its votes ripple through the cell chain, one angle per cycle, each cell
// doing one read-modify-write. The last pixel of a frame adds a drain,
// a 1451 row sweep and the last row's pass along the chain, then the result.
// After reset the same 1451 row sweep clears the store; busy is high then.
// The result strobe lasts one cycle and cannot be stalled.
// ---------------------------------------------------------------------------
module hough_line_peak_finder
   import hlpf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [7:0]               req_pixel,
   input  logic [COORD_WIDTH-1:0]   req_row,
   input  logic [COORD_WIDTH-1:0]   req_col,
   input  logic                     req_last_pixel,
   output logic                     rsp_strobe,
   output logic                     rsp_found,
   output logic signed [10:0]       rsp_peak_rho,
   output logic [7:0]               rsp_peak_theta,
   output logic [15:0]              rsp_peak_votes,
   input  logic                     csr_we,
   input  logic [1:0]               csr_index,
   input  logic [9:0]               csr_wdata
);

   localparam logic [2:0] DRAIN_LAST = 3'd3;

   state_type state_ff, state_in;
   logic [7:0] threshold_ff;
   logic [7:0] step_ff;
   logic [9:0] limit_ff;
   logic [ADDR_WIDTH-1:0] row_ff;
   logic [2:0] cnt_ff;
   logic report_ff;
   logic [VOTE_WIDTH-1:0] gv_ff;
   logic [ADDR_WIDTH-1:0] ga_ff;
   logic [7:0] gt_ff;

   vote_tok_type vote_chain [0:ANGLES];
   scan_tok_type scan_chain [0:ANGLES];
   scan_tok_type ex;
   logic accept;
   logic take;
   logic [VOTE_WIDTH-1:0] nv;
   logic [ADDR_WIDTH-1:0] na;
   logic [7:0] nt;
   logic [ADDR_WIDTH:0] lim;
   logic [ADDR_WIDTH:0] lo;
   logic [ADDR_WIDTH:0] hi;

   assign accept = start && !busy;
   assign ex = scan_chain[ANGLES];

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = req_last_pixel ? ST_DRAIN : ST_GAP;
            end
         end
         ST_GAP: state_in = ST_IDLE;
         ST_DRAIN: begin
            if (cnt_ff == DRAIN_LAST) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (row_ff == ADDR_WIDTH'(RHO_ROWS - 1)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (ex.valid && ex.last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      busy = (state_ff != ST_IDLE);
      lim = (limit_ff > 10'(RHO_MAX)) ? (ADDR_WIDTH + 1)'(RHO_MAX)
                                      : (ADDR_WIDTH + 1)'(limit_ff);
      lo = (ADDR_WIDTH + 1)'(RHO_MAX) - lim;
      hi = (ADDR_WIDTH + 1)'(RHO_MAX) + lim;
      vote_chain[0].valid = accept && (req_pixel > threshold_ff);
      vote_chain[0].row = req_row;
      vote_chain[0].col = req_col;
      vote_chain[0].phase = 8'd0;
      scan_chain[0].valid = (state_ff == ST_SWEEP);
      scan_chain[0].last = (row_ff == ADDR_WIDTH'(RHO_ROWS - 1));
      scan_chain[0].in_range = ({1'b0, row_ff} >= lo) && ({1'b0, row_ff} <= hi);
      scan_chain[0].addr = row_ff;
      scan_chain[0].votes = '0;
      scan_chain[0].theta = 8'd0;
   end

   genvar k;
   generate
      for (k = 0; k < ANGLES; k++) begin : g_cell
         hlpf_cell #(.ANGLE(k)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .step    (step_ff),
            .vote_in (vote_chain[k]),
            .vote_out(vote_chain[k+1]),
            .scan_in (scan_chain[k]),
            .scan_out(scan_chain[k+1])
         );
      end
   endgenerate

   always_comb begin
      take = ex.valid && ex.in_range && (ex.votes > gv_ff);
      nv = take ? ex.votes : gv_ff;
      na = take ? ex.addr : ga_ff;
      nt = take ? ex.theta : gt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         threshold_ff <= 8'd179;
         step_ff <= 8'd1;
         limit_ff <= 10'd725;
         row_ff <= '0;
         cnt_ff <= '0;
         report_ff <= 1'b0;
         gv_ff <= '0;
         rsp_strobe <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               REG_THRESHOLD:  threshold_ff <= csr_wdata[7:0];
               REG_ANGLE_STEP: step_ff <= csr_wdata[7:0];
               REG_RHO_LIMIT:  limit_ff <= csr_wdata;
               default: ;
            endcase
         end
         row_ff <= (state_ff == ST_SWEEP) ? row_ff + 1'b1 : '0;
         cnt_ff <= (state_ff == ST_DRAIN) ? cnt_ff + 1'b1 : '0;
         if (state_ff == ST_DRAIN) begin
            report_ff <= 1'b1;
            gv_ff <= '0;
         end else begin
            gv_ff <= nv;
         end
         rsp_strobe <= report_ff && ex.valid && ex.last;
         if (ex.valid && ex.last) begin
            report_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ga_ff <= na;
      gt_ff <= nt;
      rsp_found <= (nv != '0);
      rsp_peak_rho <= (nv != '0) ? 11'($signed({1'b0, na}) - 12'sd725) : 11'sd0;
      rsp_peak_theta <= (nv != '0) ? nt : 8'd0;
      rsp_peak_votes <= nv;
   end

endmodule

// ===== tb/hough_line_peak_finder_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// hough_line_peak_finder_tb
// Self-checking testbench for the Hough line peak finder. Pixel frames are
// fed through the start/busy request port, with random gaps. A behavioral
// vote accumulator predicts the peak reported at the end of each frame, and
// every result strobe is checked against it. The run steps through several
// register settings, the extremes among them.
// ---------------------------------------------------------------------------
module hough_line_peak_finder_tb
   import hlpf_pkg::*;
();

   typedef struct {
      logic [7:0]             pixel;
      logic [COORD_WIDTH-1:0] row;
      logic [COORD_WIDTH-1:0] col;
      logic                   last;
   } pixel_req_type;

   typedef struct {
      logic                   found;
      logic signed [10:0]     rho;
      logic [7:0]             theta;
      logic [15:0]            votes;
   } peak_type;

   localparam int         SAT_COUNT      = 65535;
   localparam longint     CYCLE_LIMIT    = 20000000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [7:0]             req_pixel = '0;
   logic [COORD_WIDTH-1:0] req_row = '0;
   logic [COORD_WIDTH-1:0] req_col = '0;
   logic                   req_last_pixel = 1'b0;
   logic                   rsp_strobe;
   logic                   rsp_found;
   logic signed [10:0]     rsp_peak_rho;
   logic [7:0]             rsp_peak_theta;
   logic [15:0]            rsp_peak_votes;
   logic                   csr_we = 1'b0;
   logic [1:0]             csr_index = '0;
   logic [9:0]             csr_wdata = '0;

   hough_line_peak_finder i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_pixel(req_pixel), .req_row(req_row), .req_col(req_col),
      .req_last_pixel(req_last_pixel), .rsp_strobe(rsp_strobe),
      .rsp_found(rsp_found), .rsp_peak_rho(rsp_peak_rho),
      .rsp_peak_theta(rsp_peak_theta), .rsp_peak_votes(rsp_peak_votes),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Accumulator shadow state and register copies.
   int unsigned vote_count [RHO_ROWS*ANGLES];
   int          voted_cells[$];
   int          thr_reg = 179;
   int          step_reg = 1;
   int          limit_reg = 725;

   pixel_req_type pending_pixels[$];
   peak_type      expected_peaks[$];
   pixel_req_type cur_req;
   int          gap_left = 0;
   int          errors = 0;
   int          n_requests = 0;
   int          n_peaks = 0;
   int          n_found = 0;
   longint      cycles = 0;

   function automatic int sin_entry(input int d);
      return (d <= 90) ? int'(SIN_QUARTER[d]) : int'(SIN_QUARTER[180 - d]);
   endfunction

   function automatic int cos_entry(input int d);
      return (d <= 90) ? int'(SIN_QUARTER[90 - d]) : -int'(SIN_QUARTER[d - 90]);
   endfunction

   function void accumulate_pixel(input pixel_req_type p);
      int     step;
      int     sum;
      int     rho;
      int     slot;
      int     lim;
      int     best_slot;
      int     r;
      peak_type pk;
      step = (step_reg == 0) ? 1 : step_reg;
      if (int'(p.pixel) > thr_reg) begin
         for (int a = 0; a < ANGLES; a += step) begin
            sum = int'(p.col) * cos_entry(a) + int'(p.row) * sin_entry(a);
            rho = (sum < 0) ? -((-sum) >>> 14) : (sum >>> 14);
            if (rho < -RHO_MAX || rho > RHO_MAX) continue;
            slot = (rho + RHO_MAX) * ANGLES + a;
            if (vote_count[slot] == 0) voted_cells.push_back(slot);
            if (vote_count[slot] < SAT_COUNT) vote_count[slot]++;
         end
      end
      if (!p.last) return;
      lim = (limit_reg > RHO_MAX) ? RHO_MAX : limit_reg;
      best_slot = -1;
      foreach (voted_cells[i]) begin
         slot = voted_cells[i];
         r = slot / ANGLES - RHO_MAX;
         if (r < -lim || r > lim) continue;
         if (best_slot < 0 || vote_count[slot] > vote_count[best_slot] ||
             (vote_count[slot] == vote_count[best_slot] && slot < best_slot)) begin
            best_slot = slot;
         end
      end
      pk = '{1'b0, '0, '0, '0};
      if (best_slot >= 0) begin
         pk.found = 1'b1;
         pk.rho   = 11'(best_slot / ANGLES - RHO_MAX);
         pk.theta = 8'(best_slot % ANGLES);
         pk.votes = 16'(vote_count[best_slot]);
      end
      expected_peaks.push_back(pk);
      foreach (voted_cells[i]) vote_count[voted_cells[i]] = 0;
      voted_cells.delete();
   endfunction

   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 0;
      if (sel < 93) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left = 0;
      end else begin
         if (start && !busy) begin
            accumulate_pixel(cur_req);
            n_requests++;
         end
         if (start && busy) begin
            // Request still waiting; hold it.
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_pixels.size() > 0) begin
            cur_req = pending_pixels.pop_front();
            req_pixel <= cur_req.pixel;
            req_row <= cur_req.row;
            req_col <= cur_req.col;
            req_last_pixel <= cur_req.last;
            start <= 1'b1;
            gap_left = pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      peak_type exp_pk;
      if (!reset && rsp_strobe) begin
         if (expected_peaks.size() == 0) begin
            $error("unexpected result: found=%0b rho=%0d theta=%0d votes=%0d",
                   rsp_found, rsp_peak_rho, rsp_peak_theta, rsp_peak_votes);
            errors++;
         end else begin
            exp_pk = expected_peaks.pop_front();
            n_peaks++;
            if (exp_pk.found) n_found++;
            if (rsp_found !== exp_pk.found) begin
               $error("found: expected %0b, actual %0b", exp_pk.found, rsp_found);
               errors++;
            end
            if (rsp_peak_rho !== exp_pk.rho) begin
               $error("peak_rho: expected %0d, actual %0d", exp_pk.rho, rsp_peak_rho);
               errors++;
            end
            if (rsp_peak_theta !== exp_pk.theta) begin
               $error("peak_theta: expected %0d, actual %0d", exp_pk.theta,
                      rsp_peak_theta);
               errors++;
            end
            if (rsp_peak_votes !== exp_pk.votes) begin
               $error("peak_votes: expected %0d, actual %0d", exp_pk.votes,
                      rsp_peak_votes);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("== FAIL ==");
         $finish;
      end
   end

   task automatic add_pixel(input int pixel, input int row, input int col,
                            input bit last);
      pixel_req_type p;
      p.pixel = 8'(pixel);
      p.row = 9'(row);
      p.col = 9'(col);
      p.last = last;
      pending_pixels.push_back(p);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_pixels.size() > 0 || start || expected_peaks.size() > 0 || busy);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] index, input int value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= 10'(value);
      case (index)
         REG_THRESHOLD:  thr_reg = value & 8'hFF;
         REG_ANGLE_STEP: step_reg = value & 8'hFF;
         REG_RHO_LIMIT:  limit_reg = value & 10'h3FF;
         default: ;
      endcase
   endtask

   task automatic configure(input int thr, input int step, input int lim);
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_ANGLE_STEP, step);
      write_reg(REG_RHO_LIMIT, lim);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // A frame is mostly pixels along one line plus some scattered noise.
   task automatic add_frame(output int count);
      int len;
      int kind;
      int fixed;
      int v;
      len = $urandom_range(1, 25);
      kind = $urandom_range(0, 3);
      fixed = $urandom_range(0, 511);
      for (int i = 0; i < len; i++) begin
         v = $urandom_range(0, 511);
         if ($urandom_range(0, 3) == 0) begin
            add_pixel($urandom_range(0, 255), $urandom_range(0, 511),
                      $urandom_range(0, 511), i == len - 1);
         end else begin
            case (kind)
               0: add_pixel($urandom_range(0, 255), fixed, v, i == len - 1);
               1: add_pixel($urandom_range(0, 255), v, fixed, i == len - 1);
               2: add_pixel($urandom_range(0, 255), v, v, i == len - 1);
               default: add_pixel($urandom_range(0, 255), v, 511 - v, i == len - 1);
            endcase
         end
      end
      count = len;
   endtask

   initial begin
      int settings [8][3];
      int frame_len;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      wait_idle();

      // Reset settings: threshold edge, corners and extreme coordinates.
      add_pixel(180, 0, 0, 0);
      add_pixel(179, 511, 511, 0);
      add_pixel(255, 511, 511, 0);
      add_pixel(200, 0, 511, 0);
      add_pixel(200, 511, 0, 1);
      add_pixel(100, 3, 3, 1);
      add_pixel(255, 511, 511, 1);
      wait_idle();

      // Zero step acts as one, zero limit scans rho 0 only.
      configure(0, 0, 0);
      add_pixel(0, 9, 9, 0);
      add_pixel(1, 100, 0, 0);
      add_pixel(1, 0, 0, 0);
      add_pixel(1, 200, 200, 1);
      add_pixel(1, 300, 0, 1);
      wait_idle();

      // Large step votes angle 0 only; limit above the store.
      configure(255, 180, 1023);
      add_pixel(255, 1, 1, 1);
      wait_idle();
      configure(0, 255, 1);
      add_pixel(77, 4, 1, 0);
      add_pixel(77, 9, 1, 1);
      add_pixel(128, 0, 2, 1);
      add_pixel(64, 0, 511, 1);
      wait_idle();

      settings = '{'{179, 1, 725}, '{0, 1, 1023}, '{255, 180, 512},
                   '{128, 7, 300}, '{30, 1, 1}, '{200, 45, 725},
                   '{90, 3, 0}, '{10, 90, 650}};
      for (int s = 0; s < 8; s++) begin
         if (s >= 3) begin
            settings[s][0] = $urandom_range(0, 255);
            settings[s][2] = $urandom_range(0, 1023);
         end
         configure(settings[s][0], settings[s][1], settings[s][2]);
         for (int n = 0; n < 210; ) begin
            add_frame(frame_len);
            n = n + frame_len;
            wait (pending_pixels.size() < 30);
         end
         wait_idle();
      end

      $display("%0d pixel requests over several register settings, %0d peaks checked",
               n_requests, n_peaks);
      $display("%0d frames reported a line, %0d errors", n_found, errors);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
